### src/swcc_pkg.sv
// Shared types and constants of the sliding-window congestion controller.
package swcc_pkg;

  localparam int SEQ_WIDTH_DEF = 16;
  localparam int CNT_WIDTH     = 16;
  localparam int DUP_WIDTH     = 3;

  // reset values of the configuration registers
  localparam logic [CNT_WIDTH-1:0] RWND_RST   = 16'd20;
  localparam logic [CNT_WIDTH-1:0] PCOUNT_RST = 16'd1;
  localparam logic [CNT_WIDTH-1:0] THRESH_RST = 16'd16;

  localparam logic [CNT_WIDTH-1:0] CNT_MAX     = '1;
  localparam logic [CNT_WIDTH-1:0] FR_INFLATE  = 16'd3;
  localparam logic [DUP_WIDTH-1:0] DUP_TRIGGER = 3'd3;
  localparam logic [DUP_WIDTH-1:0] DUP_LATCHED = 3'd4;

  typedef enum logic [1:0] {
    OP_ACK   = 2'd0,
    OP_SEND  = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_RWND   = 2'd0,
    CFG_PCOUNT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_index_t;

  // one result item
  typedef struct packed {
    logic                 send_grant;
    logic [15:0]          send_seq;
    logic                 last_packet;
    logic                 retransmit;
    logic [15:0]          retransmit_seq;
    logic [15:0]          window_base;
    logic [CNT_WIDTH-1:0] send_window;
    logic [CNT_WIDTH-1:0] cong_window;
    logic [CNT_WIDTH-1:0] slow_start_threshold;
    logic                 transfer_done;
  } result_t;

endpackage

### src/swcc_update.sv
// Per-event next-state and result logic of the congestion controller.
module swcc_update #(
  parameter int SEQ_WIDTH = swcc_pkg::SEQ_WIDTH_DEF
) (
  input  logic [swcc_pkg::CNT_WIDTH-1:0] rwnd,
  input  logic [swcc_pkg::CNT_WIDTH-1:0] pcount,
  input  logic [swcc_pkg::CNT_WIDTH-1:0] init_thresh,
  input  logic [1:0]                     opcode,
  input  logic [15:0]                    ack_number,
  input  logic                           ack_ok,
  input  logic [SEQ_WIDTH-1:0]           tx_seq,
  input  logic [SEQ_WIDTH-1:0]           base_seq,
  input  logic [swcc_pkg::CNT_WIDTH-1:0] cwnd,
  input  logic [swcc_pkg::CNT_WIDTH-1:0] thresh,
  input  logic [swcc_pkg::DUP_WIDTH-1:0] dup_count,
  input  logic [SEQ_WIDTH-1:0]           last_ack,
  input  logic [SEQ_WIDTH-1:0]           exp_mark,
  input  logic                           done,
  output logic [SEQ_WIDTH-1:0]           tx_seq_next,
  output logic [SEQ_WIDTH-1:0]           base_seq_next,
  output logic [swcc_pkg::CNT_WIDTH-1:0] cwnd_next,
  output logic [swcc_pkg::CNT_WIDTH-1:0] thresh_next,
  output logic [swcc_pkg::DUP_WIDTH-1:0] dup_count_next,
  output logic [SEQ_WIDTH-1:0]           last_ack_next,
  output logic [SEQ_WIDTH-1:0]           exp_mark_next,
  output logic                           done_next,
  output swcc_pkg::result_t              result
);

  // compare width covers both the sequence space and 16-bit counts plus a carry
  localparam int XW = ((SEQ_WIDTH > 16) ? SEQ_WIDTH : 16) + 2;
  localparam logic [SEQ_WIDTH-1:0] SEQ_MAX = '1;
  localparam logic [SEQ_WIDTH-1:0] SEQ_ONE = SEQ_WIDTH'(1);

  logic [XW-1:0]                    ack_x;
  logic [SEQ_WIDTH-1:0]             ack_s;
  logic [swcc_pkg::CNT_WIDTH-1:0]   swnd_old;
  logic                             win_ok;
  logic                             cnt_ok;
  logic                             is_last;
  logic                             done_hit;
  logic [swcc_pkg::CNT_WIDTH-1:0]   cwnd_inc;
  logic [swcc_pkg::CNT_WIDTH-1:0]   cwnd_dbl;
  logic [swcc_pkg::CNT_WIDTH-1:0]   cwnd_adv;
  logic [swcc_pkg::CNT_WIDTH-1:0]   swnd_adv;
  logic [XW-1:0]                    grow;
  logic [SEQ_WIDTH-1:0]             exp_adv;
  logic                             dup_low;
  logic [swcc_pkg::DUP_WIDTH-1:0]   dup_inc;
  logic [swcc_pkg::CNT_WIDTH-1:0]   cwnd_dup;
  logic [swcc_pkg::CNT_WIDTH-1:0]   cwnd_half;
  logic [XW-1:0]                    base_x;
  logic [XW-1:0]                    next_x;
  logic [XW-1:0]                    prev_x;

  assign ack_x = XW'(ack_number);
  assign ack_s = ack_x[SEQ_WIDTH-1:0];

  // send test on the state before the event
  assign swnd_old = (cwnd < rwnd) ? cwnd : rwnd;
  assign win_ok   = XW'(tx_seq) < (XW'(base_seq) + XW'(swnd_old));
  assign cnt_ok   = XW'(tx_seq) <= XW'(pcount);
  assign is_last  = XW'(tx_seq) == XW'(pcount);
  assign done_hit = XW'(ack_s) == (XW'(pcount) + XW'(1));

  // window growth on a new ACK
  assign cwnd_inc = (cwnd == swcc_pkg::CNT_MAX) ? cwnd : cwnd + 16'd1;
  assign cwnd_dbl = cwnd[swcc_pkg::CNT_WIDTH-1] ? swcc_pkg::CNT_MAX : {cwnd[14:0], 1'b0};
  assign cwnd_adv = (cwnd < thresh) ? cwnd_dbl : cwnd_inc;
  assign swnd_adv = (cwnd_adv < rwnd) ? cwnd_adv : rwnd;
  assign grow     = XW'(exp_mark) + XW'(swnd_adv);
  assign exp_adv  = (grow > XW'(SEQ_MAX)) ? SEQ_MAX : grow[SEQ_WIDTH-1:0];

  // duplicate ACK path; counter stops once latched
  assign dup_low   = dup_count < swcc_pkg::DUP_TRIGGER;
  assign dup_inc   = dup_low ? dup_count + 3'd1 : dup_count;
  assign cwnd_dup  = dup_low ? cwnd_inc : cwnd;
  assign cwnd_half = {1'b0, cwnd_dup[swcc_pkg::CNT_WIDTH-1:1]};

  assign prev_x = XW'(last_ack);
  assign next_x = XW'(tx_seq);

  always_comb begin
    tx_seq_next    = tx_seq;
    base_seq_next  = base_seq;
    cwnd_next      = cwnd;
    thresh_next    = thresh;
    dup_count_next = dup_count;
    last_ack_next  = last_ack;
    exp_mark_next  = exp_mark;
    done_next      = done;
    result         = '0;
    case (opcode)
      swcc_pkg::OP_START: begin
        tx_seq_next    = SEQ_ONE;
        base_seq_next  = SEQ_ONE;
        cwnd_next      = 16'd1;
        thresh_next    = init_thresh;
        dup_count_next = '0;
        last_ack_next  = '0;
        exp_mark_next  = SEQ_WIDTH'(2);
        done_next      = 1'b0;
      end
      swcc_pkg::OP_SEND: begin
        if (!done && cnt_ok && win_ok) begin
          result.send_grant  = 1'b1;
          result.send_seq    = next_x[15:0];
          result.last_packet = is_last;
          tx_seq_next        = tx_seq + SEQ_ONE;
        end
      end
      swcc_pkg::OP_ACK: begin
        if (ack_ok && !done) begin
          if (ack_s > last_ack) begin
            dup_count_next = '0;
            if (ack_s >= exp_mark) begin
              base_seq_next = ack_s;
              cwnd_next     = cwnd_adv;
              exp_mark_next = exp_adv;
            end
            last_ack_next = ack_s;
          end else if (ack_s == last_ack) begin
            dup_count_next = dup_inc;
            cwnd_next      = cwnd_dup;
            if (dup_inc == swcc_pkg::DUP_TRIGGER) begin
              result.retransmit     = 1'b1;
              result.retransmit_seq = prev_x[15:0];
              thresh_next           = cwnd_half;
              cwnd_next             = cwnd_half + swcc_pkg::FR_INFLATE;
              dup_count_next        = swcc_pkg::DUP_LATCHED;
            end
          end
          if (done_hit) begin
            done_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // status fields report the state after the event
    base_x                      = XW'(base_seq_next);
    result.window_base          = base_x[15:0];
    result.send_window          = (cwnd_next < rwnd) ? cwnd_next : rwnd;
    result.cong_window          = cwnd_next;
    result.slow_start_threshold = thresh_next;
    result.transfer_done        = done_next;
  end

endmodule

### src/sliding_window_congestion_control.sv
// Top level of the sliding-window congestion controller.
// Sender-side window and congestion control in the Reno manner. One event item
// is taken per clock: ACK, send-slot request or start of a new transfer. The
// whole update is one pass of short logic from the event and the state
// registers into the state and a registered result, so while in_ready is high
// an item is accepted every cycle and its result appears on out_valid in the
// next cycle. in_ready is low only while a result is held by out_ready low;
// the result register is the single buffer between the two sides. The three
// configuration registers are written through cfg_we/cfg_index/cfg_data with
// no handshake; write them only while no result is pending. cwnd and the ACK
// mark saturate, sequence numbers wrap at SEQ_WIDTH bits, and no send is
// granted after the final ACK until a start event.
module sliding_window_congestion_control #(
  parameter int SEQ_WIDTH = swcc_pkg::SEQ_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] ack_number,
  input  logic        ack_ok,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send_grant,
  output logic [15:0] send_seq,
  output logic        last_packet,
  output logic        retransmit,
  output logic [15:0] retransmit_seq,
  output logic [15:0] window_base,
  output logic [15:0] send_window,
  output logic [15:0] cong_window,
  output logic [15:0] slow_start_threshold,
  output logic        transfer_done
);

  localparam logic [SEQ_WIDTH-1:0] SEQ_ONE = SEQ_WIDTH'(1);

  // configuration registers
  logic [swcc_pkg::CNT_WIDTH-1:0] rwnd;
  logic [swcc_pkg::CNT_WIDTH-1:0] pcount;
  logic [swcc_pkg::CNT_WIDTH-1:0] init_thresh;

  // transfer state
  logic [SEQ_WIDTH-1:0]           tx_seq;
  logic [SEQ_WIDTH-1:0]           base_seq;
  logic [swcc_pkg::CNT_WIDTH-1:0] cwnd;
  logic [swcc_pkg::CNT_WIDTH-1:0] thresh;
  logic [swcc_pkg::DUP_WIDTH-1:0] dup_count;
  logic [SEQ_WIDTH-1:0]           last_ack;
  logic [SEQ_WIDTH-1:0]           exp_mark;
  logic                           done;

  logic [SEQ_WIDTH-1:0]           tx_seq_next;
  logic [SEQ_WIDTH-1:0]           base_seq_next;
  logic [swcc_pkg::CNT_WIDTH-1:0] cwnd_next;
  logic [swcc_pkg::CNT_WIDTH-1:0] thresh_next;
  logic [swcc_pkg::DUP_WIDTH-1:0] dup_count_next;
  logic [SEQ_WIDTH-1:0]           last_ack_next;
  logic [SEQ_WIDTH-1:0]           exp_mark_next;
  logic                           done_next;

  swcc_pkg::result_t              res_next;
  swcc_pkg::result_t              res;
  logic                           accept;

  // a result is held until taken; a new item enters whenever the slot frees
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rwnd        <= swcc_pkg::RWND_RST;
      pcount      <= swcc_pkg::PCOUNT_RST;
      init_thresh <= swcc_pkg::THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swcc_pkg::CFG_RWND:   rwnd        <= cfg_data;
        swcc_pkg::CFG_PCOUNT: pcount      <= cfg_data;
        swcc_pkg::CFG_THRESH: init_thresh <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  swcc_update #(
    .SEQ_WIDTH(SEQ_WIDTH)
  ) u_update (
    .rwnd           (rwnd),
    .pcount         (pcount),
    .init_thresh    (init_thresh),
    .opcode         (opcode),
    .ack_number     (ack_number),
    .ack_ok         (ack_ok),
    .tx_seq         (tx_seq),
    .base_seq       (base_seq),
    .cwnd           (cwnd),
    .thresh         (thresh),
    .dup_count      (dup_count),
    .last_ack       (last_ack),
    .exp_mark       (exp_mark),
    .done           (done),
    .tx_seq_next    (tx_seq_next),
    .base_seq_next  (base_seq_next),
    .cwnd_next      (cwnd_next),
    .thresh_next    (thresh_next),
    .dup_count_next (dup_count_next),
    .last_ack_next  (last_ack_next),
    .exp_mark_next  (exp_mark_next),
    .done_next      (done_next),
    .result         (res_next)
  );

  // state advances only on an accepted item; reset equals a start event
  // with the default threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_seq    <= SEQ_ONE;
      base_seq  <= SEQ_ONE;
      cwnd      <= 16'd1;
      thresh    <= swcc_pkg::THRESH_RST;
      dup_count <= '0;
      last_ack  <= '0;
      exp_mark  <= SEQ_WIDTH'(2);
      done      <= 1'b0;
    end else if (accept) begin
      tx_seq    <= tx_seq_next;
      base_seq  <= base_seq_next;
      cwnd      <= cwnd_next;
      thresh    <= thresh_next;
      dup_count <= dup_count_next;
      last_ack  <= last_ack_next;
      exp_mark  <= exp_mark_next;
      done      <= done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign send_grant           = res.send_grant;
  assign send_seq             = res.send_seq;
  assign last_packet          = res.last_packet;
  assign retransmit           = res.retransmit;
  assign retransmit_seq       = res.retransmit_seq;
  assign window_base          = res.window_base;
  assign send_window          = res.send_window;
  assign cong_window          = res.cong_window;
  assign slow_start_threshold = res.slow_start_threshold;
  assign transfer_done        = res.transfer_done;

  // the duplicate counter jumps from the trigger count straight to latched
  a_dup_never_trigger: assert property (@(posedge clk) disable iff (rst)
    dup_count != swcc_pkg::DUP_TRIGGER)
    else $error("duplicate counter rests at trigger count");

  // cwnd starts at one, is set back to one by a start event, and otherwise only grows or is reloaded with threshold + 3
  a_cwnd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cwnd != '0)
    else $error("congestion window reached zero");

  // a fast retransmit leaves cwnd inflated by three over the new threshold
  a_fr_inflate: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.retransmit |->
      res.cong_window == res.slow_start_threshold + swcc_pkg::FR_INFLATE)
    else $error("fast retransmit window mismatch");

  // without a grant the send fields are clear
  a_no_grant_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.send_grant |-> res.send_seq == '0 && !res.last_packet)
    else $error("send fields set without grant");

  // a start event restarts the transfer
  a_start_restart: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == swcc_pkg::OP_START |=>
      tx_seq == SEQ_ONE && base_seq == SEQ_ONE && !done && dup_count == '0)
    else $error("start event did not restart transfer");

endmodule
